>>> rtl/rrgt_pkg.sv
// Package for the receive gap tracker: widths, codes, verdicts, FSM states.
// No dependencies.
`default_nettype none
package rrgt_pkg;
   localparam int SENDER_SLOTS_DEF = 16;
   localparam int WISH_DEPTH_DEF   = 128;
   localparam int HEADER_BYTES_DEF = 32;

   localparam logic [7:0] VER_FIRST  = 8'h54;   // 'T'
   localparam logic [7:0] VER_SECOND = 8'h34;   // '4'

   localparam int        MAX_WISH_W     = 7;
   localparam int        CSR_DATA_W     = 32;
   localparam logic [6:0] MAX_WISH_RESET = 7'd100;
   localparam logic [6:0] GAPS_SAT       = 7'd127;

   // register indexes
   localparam logic CSR_MAX_WISH = 1'b0;
   localparam logic CSR_OWN_ID   = 1'b1;

   typedef enum logic [2:0] {
      VERDICT_BAD_VERSION = 3'd0,
      VERDICT_TOO_SHORT   = 3'd1,
      VERDICT_LOOPBACK    = 3'd2,
      VERDICT_NOT_REQ     = 3'd3,
      VERDICT_REDEL_REQ   = 3'd4,
      VERDICT_DELIVER     = 3'd5
   } verdict_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REM_RD,
      ST_REM_CMP,
      ST_SND_RD,
      ST_SND_CMP,
      ST_SND_DONE,
      ST_GAP_CALC,
      ST_GAP_SPLIT,
      ST_MOVE_RD,
      ST_MOVE_WR,
      ST_APPEND,
      ST_FINISH
   } state_type;
endpackage
`default_nettype wire

>>> rtl/rrgt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module rrgt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

>>> rtl/rrgt_gap_calc.sv
// Closed-form gap batch sizing: ids to handle (a) and final list length (f).
// Depends on rrgt_pkg.
`default_nettype none
module rrgt_gap_calc
   import rrgt_pkg::*;
#(
   parameter int WISH_DEPTH = WISH_DEPTH_DEF,
   localparam int LEN_W = $clog2(WISH_DEPTH + 1)
) (
   input  wire logic [31:0]           first_id,
   input  wire logic [31:0]           upto_id,
   input  wire logic [LEN_W-1:0]      len,
   input  wire logic [MAX_WISH_W-1:0] max_wish,
   output logic      [31:0]           batch,
   output logic      [LEN_W-1:0]      final_len
);
   localparam logic [32:0] DEPTH_X = 33'(WISH_DEPTH);
   logic [31:0] g;
   logic [32:0] l0x, mx, ax, sum, fx;
   logic        over;

   always_comb begin
      g    = upto_id - first_id;
      l0x  = {{(33-LEN_W){1'b0}}, len};
      mx   = {{(33-MAX_WISH_W){1'b0}}, max_wish};
      over = l0x > mx;
      if (!over && len == '0 && {1'b0, g} > mx) begin
         batch = {{(32-MAX_WISH_W){1'b0}}, max_wish};
      end else begin
         batch = g;
      end
      ax  = {1'b0, batch};
      sum = l0x + ax;
      if (over) begin
         fx = l0x;
      end else if (sum < mx + 33'd1) begin
         fx = sum;
      end else begin
         fx = mx + 33'd1;
      end
      if (fx > DEPTH_X) begin
         fx = DEPTH_X;
      end
      final_len = fx[LEN_W-1:0];
   end
endmodule
`default_nettype wire

>>> rtl/reliable_receive_gap_tracker.sv
// Receive gap tracker: one header beat in, one verdict beat out.
// One header in flight; a finished result waits in the output register while the
// next header is taken.
// Reset (synchronous): list empty, sender table empty, max_wish 100, own_id 0.
`default_nettype none
module reliable_receive_gap_tracker
   import rrgt_pkg::*;
#(
   parameter int SENDER_SLOTS = SENDER_SLOTS_DEF,
   parameter int WISH_DEPTH   = WISH_DEPTH_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // header beat
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // version_first, version_second, payload_size, received_bytes, sender_id, packet_id
   input  wire logic [111:0]          req_tdata,
   // is_reliable, is_redelivery, is_cannot_redeliver, is_redelivery_request
   input  wire logic [3:0]            req_tuser,
   // verdict beat
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // verdict, gaps_added, wish_count, sender_untracked (zero filled)
   output logic [23:0]                rsp_tdata,
   // register writes
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);
   localparam int LEN_W  = $clog2(WISH_DEPTH + 1);
   localparam int WA_W   = (WISH_DEPTH > 1) ? $clog2(WISH_DEPTH) : 1;
   localparam int SCNT_W = $clog2(SENDER_SLOTS + 1);
   localparam int SA_W   = (SENDER_SLOTS > 1) ? $clog2(SENDER_SLOTS) : 1;
   localparam logic [SCNT_W-1:0] SLOTS_C   = SCNT_W'(SENDER_SLOTS);
   localparam logic [16:0]       HDR_BYTES = 17'(HEADER_BYTES);

   // configuration
   logic [MAX_WISH_W-1:0] max_wish_ff;
   logic [31:0]           own_id_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_wish_ff <= MAX_WISH_RESET;
         own_id_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_addr)
            CSR_MAX_WISH: max_wish_ff <= csr_wr_data[MAX_WISH_W-1:0];
            CSR_OWN_ID:   own_id_ff   <= csr_wr_data[31:0];
            default:      ;
         endcase
      end
   end

   // captured header
   logic [7:0]  ver1_ff, ver2_ff;
   logic [15:0] psize_ff, rbytes_ff;
   logic [31:0] snd_ff, pkt_ff;
   logic        rel_ff, redel_ff, cant_ff, req_ff;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         ver1_ff   <= req_tdata[7:0];
         ver2_ff   <= req_tdata[15:8];
         psize_ff  <= req_tdata[31:16];
         rbytes_ff <= req_tdata[47:32];
         snd_ff    <= req_tdata[79:48];
         pkt_ff    <= req_tdata[111:80];
         rel_ff    <= req_tuser[0];
         redel_ff  <= req_tuser[1];
         cant_ff   <= req_tuser[2];
         req_ff    <= req_tuser[3];
      end
   end

   // working registers
   logic [LEN_W-1:0]  wlen_ff, wlen_in;
   logic [LEN_W-1:0]  rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   logic              hit_ff, hit_in;
   logic [SCNT_W-1:0] scan_ff, scan_in;
   logic              found_ff, found_in, free_ok_ff, free_ok_in;
   logic [SA_W-1:0]   slot_ff, slot_in, free_ff, free_in;
   logic [31:0]       first_ff, first_in;
   logic [31:0]       batch_ff, batch_in, id_ff, id_in;
   logic [LEN_W-1:0]  flen_ff, flen_in, keep_ff, keep_in;
   logic [2:0]        verdict_ff, verdict_in;
   logic [6:0]        gaps_ff, gaps_in;
   logic              untracked_ff, untracked_in;
   logic              valid_ff [SENDER_SLOTS];
   logic              set_valid;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [23:0]       rsp_data_ff, rsp_data_in;

   // wish RAM: {packet, sender}
   logic             w_we, w_re;
   logic [WA_W-1:0]  w_waddr, w_raddr;
   logic [63:0]      w_wdata, w_rdata;
   // sender RAM: {last id, sender id}
   logic             s_we, s_re;
   logic [SA_W-1:0]  s_waddr, s_raddr;
   logic [63:0]      s_wdata, s_rdata;

   rrgt_ram #(.WIDTH(64), .DEPTH(WISH_DEPTH)) u_wish_ram (
      .clock(clock), .wr_en(w_we), .wr_addr(w_waddr), .wr_data(w_wdata),
      .rd_en(w_re), .rd_addr(w_raddr), .rd_data(w_rdata)
   );

   rrgt_ram #(.WIDTH(64), .DEPTH(SENDER_SLOTS)) u_sender_ram (
      .clock(clock), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
      .rd_en(s_re), .rd_addr(s_raddr), .rd_data(s_rdata)
   );

   logic [31:0]      calc_batch;
   logic [LEN_W-1:0] calc_flen;

   rrgt_gap_calc #(.WISH_DEPTH(WISH_DEPTH)) u_gap_calc (
      .first_id(first_ff), .upto_id(pkt_ff), .len(wlen_ff), .max_wish(max_wish_ff),
      .batch(calc_batch), .final_len(calc_flen)
   );

   // header checks
   logic        bad_version, too_short, loopback, notice;
   logic [31:0] pred_id;
   logic [LEN_W-1:0] split_s;
   logic [SA_W-1:0]  scan_idx;
   logic [LEN_W+7:0] wlen_wide;

   always_comb begin
      bad_version = (ver1_ff != VER_FIRST) || (ver2_ff != VER_SECOND);
      too_short   = ({1'b0, psize_ff} + HDR_BYTES) > {1'b0, rbytes_ff};
      loopback    = snd_ff == own_id_ff;
      notice      = redel_ff || cant_ff;
      pred_id     = s_rdata[63:32] + 32'd1;
      scan_idx    = scan_ff[SA_W-1:0];
      // s = min(batch, f); batch wider than the list is clipped by f
      if (batch_ff < {{(32-LEN_W){1'b0}}, flen_ff}) begin
         split_s = batch_ff[LEN_W-1:0];
      end else begin
         split_s = flen_ff;
      end
      wlen_wide = {8'd0, wlen_ff};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_tvalid) state_in = ST_CHECK;
         ST_CHECK: begin
            if (bad_version || too_short || loopback) state_in = ST_FINISH;
            else if (notice)                           state_in = ST_REM_RD;
            else if (req_ff)                           state_in = ST_FINISH;
            else if (rel_ff)                           state_in = ST_SND_RD;
            else                                       state_in = ST_FINISH;
         end
         ST_REM_RD: begin
            if (rd_ptr_ff == wlen_ff) begin
               state_in = (hit_ff && rel_ff) ? ST_SND_RD : ST_FINISH;
            end else begin
               state_in = ST_REM_CMP;
            end
         end
         ST_REM_CMP:   state_in = ST_REM_RD;
         ST_SND_RD:    state_in = (scan_ff == SLOTS_C) ? ST_SND_DONE : ST_SND_CMP;
         ST_SND_CMP:   state_in = ST_SND_RD;
         ST_SND_DONE: begin
            // sender RAM data still holds the matched slot (re-read below)
            state_in = ST_FINISH;
            if (found_ff && pkt_ff > pred_id) state_in = ST_GAP_CALC;
         end
         ST_GAP_CALC:  state_in = ST_GAP_SPLIT;
         ST_GAP_SPLIT: begin
            if (keep_in != '0 && keep_in < wlen_ff) state_in = ST_MOVE_RD;
            else                                    state_in = ST_APPEND;
         end
         ST_MOVE_RD:   state_in = (wr_ptr_ff == keep_ff) ? ST_APPEND : ST_MOVE_WR;
         ST_MOVE_WR:   state_in = ST_MOVE_RD;
         ST_APPEND:    if (wr_ptr_ff == flen_ff) state_in = ST_FINISH;
         ST_FINISH:    if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      req_tready   = state_ff == ST_IDLE;
      wlen_in      = wlen_ff;
      rd_ptr_in    = rd_ptr_ff;
      wr_ptr_in    = wr_ptr_ff;
      hit_in       = hit_ff;
      scan_in      = scan_ff;
      found_in     = found_ff;
      free_ok_in   = free_ok_ff;
      slot_in      = slot_ff;
      free_in      = free_ff;
      first_in     = first_ff;
      batch_in     = batch_ff;
      id_in        = id_ff;
      flen_in      = flen_ff;
      keep_in      = keep_ff;
      verdict_in   = verdict_ff;
      gaps_in      = gaps_ff;
      untracked_in = untracked_ff;
      set_valid    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      w_we = 1'b0; w_re = 1'b0;
      w_waddr = wr_ptr_ff[WA_W-1:0];
      w_raddr = rd_ptr_ff[WA_W-1:0];
      w_wdata = w_rdata;
      s_we = 1'b0; s_re = 1'b0;
      s_waddr = found_ff ? slot_ff : free_ff;
      s_raddr = scan_idx;
      s_wdata = {pkt_ff, snd_ff};

      case (state_ff)
         ST_CHECK: begin
            gaps_in      = '0;
            untracked_in = 1'b0;
            rd_ptr_in    = '0;
            wr_ptr_in    = '0;
            hit_in       = 1'b0;
            scan_in      = '0;
            found_in     = 1'b0;
            free_ok_in   = 1'b0;
            verdict_in   = VERDICT_DELIVER;
            if (bad_version)   verdict_in = VERDICT_BAD_VERSION;
            else if (too_short) verdict_in = VERDICT_TOO_SHORT;
            else if (loopback)  verdict_in = VERDICT_LOOPBACK;
            else if (!notice && req_ff) verdict_in = VERDICT_REDEL_REQ;
         end
         ST_REM_RD: begin
            if (rd_ptr_ff == wlen_ff) begin
               wlen_in = wr_ptr_ff;
               if (!hit_ff) verdict_in = VERDICT_NOT_REQ;
            end else begin
               w_re = 1'b1;
            end
         end
         ST_REM_CMP: begin
            // compact: entries that do not match slide down to the write pointer
            if (w_rdata[31:0] == snd_ff && w_rdata[63:32] == pkt_ff) begin
               hit_in = 1'b1;
            end else begin
               w_we      = 1'b1;
               wr_ptr_in = wr_ptr_ff + 1'b1;
            end
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
         ST_SND_RD: begin
            if (scan_ff != SLOTS_C) begin
               s_re = 1'b1;
            end else if (found_ff) begin
               s_re    = 1'b1;
               s_raddr = slot_ff;
            end
         end
         ST_SND_CMP: begin
            if (valid_ff[scan_idx]) begin
               if (!found_ff && s_rdata[31:0] == snd_ff) begin
                  found_in = 1'b1;
                  slot_in  = scan_idx;
               end
            end else if (!free_ok_ff) begin
               free_ok_in = 1'b1;
               free_in    = scan_idx;
            end
            scan_in = scan_ff + 1'b1;
         end
         ST_SND_DONE: begin
            first_in = pred_id;
            if (found_ff) begin
               s_we = 1'b1;
            end else if (free_ok_ff) begin
               s_we      = 1'b1;
               set_valid = 1'b1;
            end else begin
               untracked_in = 1'b1;
            end
         end
         ST_GAP_CALC: begin
            batch_in = calc_batch;
            flen_in  = calc_flen;
            gaps_in  = (calc_batch > 32'(GAPS_SAT)) ? GAPS_SAT : calc_batch[6:0];
         end
         ST_GAP_SPLIT: begin
            keep_in   = flen_ff - split_s;
            id_in     = first_ff + (batch_ff - {{(32-LEN_W){1'b0}}, split_s});
            rd_ptr_in = wlen_ff - keep_in;
            wr_ptr_in = (keep_in != '0 && keep_in < wlen_ff) ? '0 : keep_in;
         end
         ST_MOVE_RD: begin
            if (wr_ptr_ff != keep_ff) w_re = 1'b1;
         end
         ST_MOVE_WR: begin
            w_we      = 1'b1;
            rd_ptr_in = rd_ptr_ff + 1'b1;
            wr_ptr_in = wr_ptr_ff + 1'b1;
         end
         ST_APPEND: begin
            if (wr_ptr_ff == flen_ff) begin
               wlen_in = flen_ff;
            end else begin
               w_we      = 1'b1;
               w_wdata   = {id_ff, snd_ff};
               id_in     = id_ff + 32'd1;
               wr_ptr_in = wr_ptr_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {5'd0, untracked_ff, wlen_wide[7:0], gaps_ff, verdict_ff};
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wlen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SENDER_SLOTS; i++) valid_ff[i] <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wlen_ff      <= wlen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (set_valid) valid_ff[free_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff    <= rd_ptr_in;
      wr_ptr_ff    <= wr_ptr_in;
      hit_ff       <= hit_in;
      scan_ff      <= scan_in;
      found_ff     <= found_in;
      free_ok_ff   <= free_ok_in;
      slot_ff      <= slot_in;
      free_ff      <= free_in;
      first_ff     <= first_in;
      batch_ff     <= batch_in;
      id_ff        <= id_in;
      flen_ff      <= flen_in;
      keep_ff      <= keep_in;
      verdict_ff   <= verdict_in;
      gaps_ff      <= gaps_in;
      untracked_ff <= untracked_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
endmodule
`default_nettype wire

>>> verif/rrgt_checker.sv
// Checker for the receive gap tracker: watches the header, verdict and register ports,
// keeps its own copy of the sender table and wish list, and compares every verdict beat.
// Depends on rrgt_pkg.
`default_nettype none
module rrgt_checker
   import rrgt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [111:0]          req_tdata,
   input  wire logic [3:0]            req_tuser,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [23:0]           rsp_tdata,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data,
   output int                         verdicts_pending,
   output int                         mismatch_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EXP_SLOTS = 64;      // far more than can ever be in flight

   // laid out as on rsp_tdata, lowest field last
   typedef struct packed {
      logic        untracked;
      logic [7:0]  wish;
      logic [6:0]  gaps;
      verdict_type verdict;
   } verdict_beat_type;

   verdict_beat_type expected_verdicts[EXP_SLOTS];
   int               exp_head, exp_tail;

   logic [6:0]  max_wish_q;
   logic [31:0] own_id_q;
   logic [31:0] snd_ids[SENDER_SLOTS_DEF];
   logic [31:0] snd_last[SENDER_SLOTS_DEF];
   logic        snd_valid[SENDER_SLOTS_DEF];
   logic [31:0] wish_snd[WISH_DEPTH_DEF];
   logic [31:0] wish_pkt[WISH_DEPTH_DEF];
   logic [63:0] wish_len;

   assign verdicts_pending = exp_tail - exp_head;

   // drop every (sender, id) match, keep order; 1 if anything matched
   function automatic logic drop_wishes(logic [31:0] snd, logic [31:0] pkt);
      logic hit;
      int   w;
      hit = 1'b0;
      w = 0;
      for (int r = 0; r < wish_len; r++) begin
         if (wish_snd[r] == snd && wish_pkt[r] == pkt) begin
            hit = 1'b1;
         end else begin
            wish_snd[w] = wish_snd[r];
            wish_pkt[w] = wish_pkt[r];
            w++;
         end
      end
      wish_len = 64'(w);
      return hit;
   endfunction

   // closed form of the gap batch; returns the ids handled
   function automatic logic [63:0] append_gaps(logic [31:0] snd, logic [31:0] first,
                                               logic [31:0] upto);
      logic [63:0] g, a, f, s, keep, l0, m;
      logic [31:0] id;
      if (upto <= first) return '0;
      g  = 64'(upto) - 64'(first);
      l0 = wish_len;
      m  = 64'(max_wish_q);
      if (l0 > m)                  a = g;
      else if (l0 == 0 && g > m)   a = m;
      else                         a = g;
      if (l0 > m) f = l0;
      else        f = (l0 + a < m + 1) ? l0 + a : m + 1;
      if (f > 64'(WISH_DEPTH_DEF)) f = 64'(WISH_DEPTH_DEF);
      s    = (a < f) ? a : f;
      keep = f - s;
      if (keep > 0 && keep < l0) begin
         for (int i = 0; i < keep; i++) begin
            wish_snd[i] = wish_snd[l0 - keep + i];
            wish_pkt[i] = wish_pkt[l0 - keep + i];
         end
      end
      id = first + 32'(a - s);
      for (int i = 0; i < s; i++) begin
         wish_snd[keep + i] = snd;
         wish_pkt[keep + i] = id + 32'(i);
      end
      wish_len = f;
      return a;
   endfunction

   function automatic verdict_beat_type make_beat(verdict_type v, logic [63:0] g, logic u);
      verdict_beat_type b;
      b.verdict   = v;
      b.gaps      = (g > 127) ? GAPS_SAT : g[6:0];
      b.wish      = wish_len[7:0];
      b.untracked = u;
      return b;
   endfunction

   function automatic verdict_beat_type classify_header(logic [111:0] d, logic [3:0] fl);
      logic [7:0]  v1, v2;
      logic [15:0] psize, rbytes;
      logic [31:0] snd, pkt, pred;
      logic [63:0] gaps;
      logic        untracked;
      int          slot, freeslot;
      v1 = d[7:0];       v2 = d[15:8];
      psize = d[31:16];  rbytes = d[47:32];
      snd = d[79:48];    pkt = d[111:80];
      gaps = '0; untracked = 1'b0; slot = -1; freeslot = -1;
      if (v1 != VER_FIRST || v2 != VER_SECOND)
         return make_beat(VERDICT_BAD_VERSION, '0, 1'b0);
      if (17'(psize) + 17'(HEADER_BYTES_DEF) > 17'(rbytes))
         return make_beat(VERDICT_TOO_SHORT, '0, 1'b0);
      if (snd == own_id_q) return make_beat(VERDICT_LOOPBACK, '0, 1'b0);
      if (fl[1] || fl[2]) begin
         if (!drop_wishes(snd, pkt)) return make_beat(VERDICT_NOT_REQ, '0, 1'b0);
      end else if (fl[3]) begin
         return make_beat(VERDICT_REDEL_REQ, '0, 1'b0);
      end
      if (fl[0]) begin
         for (int i = 0; i < SENDER_SLOTS_DEF; i++) begin
            if (snd_valid[i]) begin
               if (slot < 0 && snd_ids[i] == snd) slot = i;
            end else if (freeslot < 0) begin
               freeslot = i;
            end
         end
         if (slot >= 0) begin
            pred = snd_last[slot] + 32'd1;
            if (pred != pkt) gaps = append_gaps(snd, pred, pkt);
            snd_last[slot] = pkt;
         end else if (freeslot >= 0) begin
            snd_valid[freeslot] = 1'b1;
            snd_ids[freeslot]   = snd;
            snd_last[freeslot]  = pkt;
         end else begin
            untracked = 1'b1;
         end
      end
      return make_beat(VERDICT_DELIVER, gaps, untracked);
   endfunction

   always @(posedge clock) begin
      verdict_beat_type got, want;
      if (reset) begin
         max_wish_q = MAX_WISH_RESET;
         own_id_q   = '0;
         wish_len   = '0;
         for (int i = 0; i < SENDER_SLOTS_DEF; i++) snd_valid[i] = 1'b0;
         exp_head = 0;
         exp_tail = 0;
         mismatch_count = 0;
      end else begin
         if (csr_wr_en) begin
            if (csr_addr == CSR_MAX_WISH) max_wish_q = csr_wr_data[6:0];
            else                          own_id_q   = csr_wr_data;
         end
         // a beat leaving now belongs to an older header than one entering now
         if (rsp_tvalid && rsp_tready) begin
            got = verdict_beat_type'(rsp_tdata[18:0]);
            if (exp_tail == exp_head) begin
               $error("verdict beat with nothing expected: %h", rsp_tdata);
               mismatch_count++;
            end else begin
               want = expected_verdicts[exp_head % EXP_SLOTS];
               exp_head++;
               if (got.verdict !== want.verdict) begin
                  $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                  mismatch_count++;
               end
               if (got.gaps !== want.gaps) begin
                  $error("gaps_added: expected %0d, got %0d", want.gaps, got.gaps);
                  mismatch_count++;
               end
               if (got.wish !== want.wish) begin
                  $error("wish_count: expected %0d, got %0d", want.wish, got.wish);
                  mismatch_count++;
               end
               if (got.untracked !== want.untracked) begin
                  $error("sender_untracked: expected %0d, got %0d",
                         want.untracked, got.untracked);
                  mismatch_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_verdicts[exp_tail % EXP_SLOTS] = classify_header(req_tdata, req_tuser);
            exp_tail++;
         end
      end
   end
endmodule
`default_nettype wire

>>> verif/reliable_receive_gap_tracker_tb.sv
// Top of the gap tracker testbench: clock, reset, header and register stimulus,
// verdict back-pressure, watchdog and final verdict. Depends on rrgt_pkg,
// the block and rrgt_checker.
`default_nettype none
module reliable_receive_gap_tracker_tb;
   import rrgt_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL      = 20;      // more senders than table slots
   localparam int IDLE_WAIT = 800;     // worst block latency, rounded up
   localparam int WD_LIMIT  = 40000;   // idle cycles before giving up

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // version_first, version_second, payload_size, received_bytes, sender_id, packet_id
   logic [111:0]          req_tdata = '0;
   // is_reliable, is_redelivery, is_cannot_redeliver, is_redelivery_request
   logic [3:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // verdict, gaps_added, wish_count, sender_untracked (zero filled)
   logic [23:0]           rsp_tdata;
   logic                  csr_wr_en = 1'b0;
   logic                  csr_addr = CSR_MAX_WISH;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   int verdicts_pending, mismatch_count;
   bit quiet;                          // phase with no idling on either side
   int stall_cycles;

   logic [31:0] pool_id[POOL];
   logic [31:0] pool_last[POOL];      // last id of each sender's reliable sequence

   always #4 clock = ~clock;

   reliable_receive_gap_tracker uut (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_wr_en, .csr_addr, .csr_wr_data
   );

   rrgt_checker chk (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata, .req_tuser,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .csr_wr_en, .csr_addr, .csr_wr_data,
      .verdicts_pending, .mismatch_count
   );

   // watchdog: any beat on either channel restarts the count
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WD_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // verdict side: random stall before each beat; tready only drops when a stall is drawn
   initial begin
      int w;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         w = quiet ? 0 : $urandom_range(0, 7);
         if (w > 0) begin
            rsp_tready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // one header beat; valid stays high into the next beat when no gap is drawn
   task automatic send_header(logic [7:0] v1, logic [7:0] v2, logic [15:0] psize,
                              logic [15:0] rbytes, logic [31:0] snd, logic [31:0] pkt,
                              logic [3:0] flags);
      int w;
      w = quiet ? 0 : $urandom_range(0, 7);
      if (w > 0) begin
         req_tvalid <= 1'b0;
         repeat (w) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {pkt, snd, rbytes, psize, v2, v1};
      req_tuser  <= flags;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic good_header(logic [31:0] snd, logic [31:0] pkt, logic [3:0] flags);
      logic [15:0] ps;
      ps = 16'($urandom_range(0, 65503));
      send_header(VER_FIRST, VER_SECOND, ps, 16'($urandom_range(ps + 32, 65535)),
                  snd, pkt, flags);
   endtask

   // let every verdict drain, then cover work still running behind the last one
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (verdicts_pending != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] value);
      csr_wr_en   <= 1'b1;
      csr_addr    <= idx;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   // mostly well-formed headers from the sender pool, some noise
   task automatic random_headers(int count);
      int k, p;
      logic [31:0] pkt;
      logic [3:0]  fl;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(0, 99);
         p = $urandom_range(0, POOL - 1);
         fl = 4'($urandom_range(0, 15));
         if (k < 5) begin
            send_header(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                        $urandom, $urandom, fl);
         end else if (k < 8) begin
            send_header(VER_FIRST, VER_SECOND, 16'($urandom_range(1, 65535)),
                        16'($urandom_range(0, 32)), pool_id[p], $urandom, fl);
         end else if (k < 11) begin
            good_header(pool_id[p], $urandom, fl);
         end else if (k < 13) begin
            good_header(pool_id[$urandom_range(0, 1)], $urandom, fl);  // may be own_id
         end else if (k < 30) begin
            // notice aimed at a recent gap, sometimes reliable as well
            fl = {1'($urandom), 1'($urandom), 2'b00};
            if (fl[2:1] == 2'b00) fl[1] = 1'b1;
            fl[0] = 1'($urandom);
            good_header(pool_id[p], pool_last[p] - $urandom_range(1, 12), fl);
         end else if (k < 36) begin
            good_header(pool_id[p], $urandom, 4'b1000 | {3'b000, 1'($urandom)});
         end else begin
            case ($urandom_range(0, 9))
               0:       pkt = pool_last[p] - $urandom_range(0, 50);
               1:       pkt = pool_last[p] + $urandom_range(100, 400);
               2:       pkt = $urandom;
               default: pkt = pool_last[p] + 1 + $urandom_range(0, 5);
            endcase
            pool_last[p] = pkt;
            good_header(pool_id[p], pkt, 4'b0001);
         end
      end
   endtask

   initial begin
      int unsigned mw_set[6] = '{100, 1, 127, 0, 5, 50};
      for (int i = 0; i < POOL; i++) begin
         pool_id[i]   = $urandom;
         pool_last[i] = $urandom;
      end
      pool_id[0] = 32'h0000_0000;
      pool_id[1] = 32'hFFFF_FFFF;
      quiet = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: checks order, flags, gaps, wrap, table
      send_header(8'h00, VER_SECOND, 16'd0, 16'hFFFF, 32'h5, 32'd1, 4'b0001);
      send_header(VER_FIRST, 8'hFF, 16'd0, 16'hFFFF, 32'h5, 32'd1, 4'b0001);
      send_header(8'hFF, 8'h00, 16'hFFFF, 16'd0, 32'h5, 32'd1, 4'b1111);
      send_header(VER_FIRST, VER_SECOND, 16'hFFFF, 16'hFFFF, 32'h5, 32'd1, 4'b0001);
      send_header(VER_FIRST, VER_SECOND, 16'd0, 16'd31, 32'h5, 32'd1, 4'b0001);
      send_header(VER_FIRST, VER_SECOND, 16'd0, 16'd32, 32'h0, 32'd1, 4'b0001); // loopback
      send_header(VER_FIRST, VER_SECOND, 16'hFFDF, 16'hFFFF, 32'h5, 32'd10, 4'b0001);
      good_header(32'h5, 14, 4'b0001);                                   // 3 gaps
      good_header(32'h5, 12, 4'b0010);                                   // matched notice
      good_header(32'h5, 12, 4'b0100);                                   // now unmatched
      good_header(32'h5, 11, 4'b1011);                                   // notice beats req
      good_header(32'h5, 30, 4'b1000);                                   // request
      good_header(32'h5, 13, 4'b0101);                                   // notice + reliable
      good_header(32'h5, 32'h0000_0400, 4'b0001);                        // big gap, capped
      good_header(32'h5, 7, 4'b0001);                                    // lower id
      good_header(32'h6, 32'hFFFF_FFFF, 4'b0001);
      good_header(32'h6, 32'h0000_0000, 4'b0001);                        // wrap, no gap
      good_header(32'h6, 32'h0000_0003, 4'b0001);
      good_header(32'h6, 32'h0000_0002, 4'b1110);
      drain();

      // directed: max_wish of 0 with a non-empty list, then loopback on an all-ones id
      write_reg(CSR_MAX_WISH, 0);
      write_reg(CSR_OWN_ID, 32'hFFFF_FFFF);
      good_header(32'h7, 100, 4'b0001);
      good_header(32'h7, 110, 4'b0001);
      good_header(32'hFFFF_FFFF, 1, 4'b0001);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_reg(CSR_MAX_WISH, mw_set[ph]);
         write_reg(CSR_OWN_ID, (ph % 2) ? pool_id[ph % 2] : $urandom);
         quiet = (ph == 2);
         random_headers(115);
         drain();                       // sender holds off until all verdicts are back
         random_headers(115);
         drain();
      end
      quiet = 1'b0;

      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
`default_nettype wire
